>>> hw/rtl/shkt_pkg.sv
// Shared types, sizes, codes and helpers for the sorted hash key table.
package shkt_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS   = 32;
  localparam int DATA_BITS  = 32;
  localparam int INDEX_BITS = 7;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_SET    = 1'b1
  } opcode_t;

  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  typedef struct packed {
    opcode_t opcode;
    key_t    key_hash;
    data_t   write_value;
  } in_item_t;

  typedef struct packed {
    index_t  entry_index;
    logic    key_found;
    data_t   read_value;
    status_t status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_CHECK,
    ST_SHIFT_START,
    ST_SHIFT,
    ST_INSERT,
    ST_RESPOND
  } state_t;

  // Keeps the low VALUE_BITS bits of a 32-bit word, zero-filling above it.
  function automatic value_t to_value(data_t d);
    value_t r;
    r = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (i < DATA_BITS) begin
        r[i] = d[i];
      end
    end
    return r;
  endfunction

  // Shows the low 32 bits of a stored value, zero-filling above it.
  function automatic data_t to_data(value_t v);
    data_t r;
    r = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      if (i < VALUE_BITS) begin
        r[i] = v[i];
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/shkt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module shkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/sorted_hash_key_table_unit.sv
// Top level of the sorted hash key table: sequencer, search and shift datapath, result register.
//
// This unit keeps up to 64 key hashes in ascending unsigned order, each with a
// stored value, in two single-write, single-read RAMs. A lookup answers with the
// key's sorted position and its value on a hit, or with the entry count on a
// miss. A set overwrites the value of a present key, or inserts a new key at its
// sorted position after moving every later entry up one place; a set of a new key
// into a full table leaves the table unchanged and reports full. Each transaction
// is handled alone by a small sequencer around one key comparator and the RAM read
// port. A binary search step reads the midpoint in the search state and narrows
// the range in the compare state, for at most ceil(log2(n+1)) steps for n stored
// entries. Then the search state reads the entry at the lower bound, the check
// state checks it and the respond state loads the result register, and the next
// transaction can be taken once the sequencer is back in its idle state.
// An insert adds the insert state to write the new entry and, when later entries
// must move, a shift start state and then the shift state, which moves them up
// one place in turn, as the RAM read port reads one entry per cycle.
// The input stalls from acceptance until the result is in the output register; a
// waiting result does not block the next transaction from being accepted.
// The RAMs need no clearing after reset: only entries below the count are read.
module sorted_hash_key_table_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  shkt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output shkt_pkg::out_item_t out_data
);

  shkt_pkg::state_t    state;
  shkt_pkg::state_t    state_next;

  // Entry count and search bounds.
  shkt_pkg::cnt_t      count;
  shkt_pkg::cnt_t      lo;
  shkt_pkg::cnt_t      hi;
  shkt_pkg::cnt_t      src;

  // The transaction being worked on.
  shkt_pkg::opcode_t   op_q;
  shkt_pkg::key_t      key_q;
  shkt_pkg::value_t    val_q;

  // Result waiting to move into the output register.
  shkt_pkg::out_item_t res;

  // RAM ports.
  logic                key_we;
  logic                val_we;
  shkt_pkg::addr_t     wr_addr;
  shkt_pkg::key_t      key_wdata;
  shkt_pkg::value_t    val_wdata;
  logic                rd_en;
  shkt_pkg::addr_t     rd_addr;
  shkt_pkg::key_t      key_rd;
  shkt_pkg::value_t    val_rd;

  logic [shkt_pkg::CNT_W:0] mid_sum;
  shkt_pkg::cnt_t      mid;
  logic                in_fire;
  logic                out_free;
  logic                hit;
  logic                full;
  logic                lo_below;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state != shkt_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Midpoint of the open search range; it stays below hi, so it is a real entry.
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[shkt_pkg::CNT_W:1];

  // The probed entry matches only if it lies below the entry count.
  assign lo_below = (lo < count);
  assign hit      = lo_below && (key_rd == key_q);
  assign full     = (count == shkt_pkg::cnt_t'(shkt_pkg::CAPACITY));

  shkt_ram #(
    .WIDTH(shkt_pkg::KEY_BITS),
    .DEPTH(shkt_pkg::CAPACITY)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (key_we),
    .wr_addr(wr_addr),
    .wr_data(key_wdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(key_rd)
  );

  shkt_ram #(
    .WIDTH(shkt_pkg::VALUE_BITS),
    .DEPTH(shkt_pkg::CAPACITY)
  ) u_val_ram (
    .clk    (clk),
    .wr_en  (val_we),
    .wr_addr(wr_addr),
    .wr_data(val_wdata),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(val_rd)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      shkt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = shkt_pkg::ST_SEARCH;
        end
      end
      shkt_pkg::ST_SEARCH: begin
        // While the range is open, read the midpoint; once it closes, read
        // the lower bound itself for the final match check.
        if (lo < hi) begin
          state_next = shkt_pkg::ST_COMPARE;
        end else begin
          state_next = shkt_pkg::ST_CHECK;
        end
      end
      shkt_pkg::ST_COMPARE: begin
        state_next = shkt_pkg::ST_SEARCH;
      end
      shkt_pkg::ST_CHECK: begin
        if (op_q == shkt_pkg::OP_SET && !hit && !full) begin
          if (lo_below) begin
            state_next = shkt_pkg::ST_SHIFT_START;
          end else begin
            state_next = shkt_pkg::ST_INSERT;
          end
        end else begin
          state_next = shkt_pkg::ST_RESPOND;
        end
      end
      shkt_pkg::ST_SHIFT_START: begin
        state_next = shkt_pkg::ST_SHIFT;
      end
      shkt_pkg::ST_SHIFT: begin
        if (src == lo) begin
          state_next = shkt_pkg::ST_INSERT;
        end
      end
      shkt_pkg::ST_INSERT: begin
        state_next = shkt_pkg::ST_RESPOND;
      end
      shkt_pkg::ST_RESPOND: begin
        if (out_free) begin
          state_next = shkt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = shkt_pkg::ST_IDLE;
      end
    endcase
  end

  // RAM controls for each state.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = shkt_pkg::addr_t'(lo);
    key_we    = 1'b0;
    val_we    = 1'b0;
    wr_addr   = shkt_pkg::addr_t'(lo);
    key_wdata = key_q;
    val_wdata = val_q;
    case (state)
      shkt_pkg::ST_SEARCH: begin
        if (lo < hi) begin
          rd_en   = 1'b1;
          rd_addr = shkt_pkg::addr_t'(mid);
        end else begin
          rd_en   = lo_below;
          rd_addr = shkt_pkg::addr_t'(lo);
        end
      end
      shkt_pkg::ST_CHECK: begin
        // A set of a present key rewrites its value in place.
        val_we = (op_q == shkt_pkg::OP_SET) && hit;
      end
      shkt_pkg::ST_SHIFT_START: begin
        rd_en   = 1'b1;
        rd_addr = shkt_pkg::addr_t'(src);
      end
      shkt_pkg::ST_SHIFT: begin
        // The entry read last cycle moves up one place while the next lower
        // entry is read.
        key_we    = 1'b1;
        val_we    = 1'b1;
        wr_addr   = shkt_pkg::addr_t'(src + shkt_pkg::cnt_t'(1));
        key_wdata = key_rd;
        val_wdata = val_rd;
        rd_en     = (src != lo);
        rd_addr   = shkt_pkg::addr_t'(src - shkt_pkg::cnt_t'(1));
      end
      shkt_pkg::ST_INSERT: begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= shkt_pkg::ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == shkt_pkg::ST_INSERT) begin
        count <= count + shkt_pkg::cnt_t'(1);
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == shkt_pkg::ST_RESPOND && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      shkt_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_q  <= in_data.opcode;
          key_q <= in_data.key_hash;
          val_q <= shkt_pkg::to_value(in_data.write_value);
          lo    <= '0;
          hi    <= count;
        end
      end
      shkt_pkg::ST_COMPARE: begin
        if (key_rd < key_q) begin
          lo <= mid + shkt_pkg::cnt_t'(1);
        end else begin
          hi <= mid;
        end
      end
      shkt_pkg::ST_CHECK: begin
        res.key_found  <= hit;
        res.read_value <= '0;
        res.status     <= shkt_pkg::STATUS_DONE;
        res.entry_index <= shkt_pkg::index_t'(lo);
        src            <= count - shkt_pkg::cnt_t'(1);
        if (op_q == shkt_pkg::OP_LOOKUP) begin
          if (hit) begin
            res.read_value <= shkt_pkg::to_data(val_rd);
          end else begin
            res.entry_index <= shkt_pkg::index_t'(count);
          end
        end else if (!hit && full) begin
          res.entry_index <= shkt_pkg::index_t'(count);
          res.status      <= shkt_pkg::STATUS_FULL;
        end
      end
      shkt_pkg::ST_SHIFT: begin
        if (src != lo) begin
          src <= src - shkt_pkg::cnt_t'(1);
        end
      end
      shkt_pkg::ST_RESPOND: begin
        if (out_free) begin
          out_data <= res;
        end
      end
      default: begin
        src <= src;
      end
    endcase
  end

endmodule

>>> verif/tb.sv
// Self-checking testbench for the sorted hash key table unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shkt_pkg::*;

  // Stimulus size, the length of the receiver hold-off, and the watchdog limit.
  // The limit counts cycles in which no transaction is accepted on either side.
  // It covers the hold-off plus the slowest insert.
  localparam int ITEM_GOAL       = 550;
  localparam int TAIL_ITEMS      = 60;
  localparam int HOLD_OFF_AT     = 180;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 100;
  localparam int STUCK_LIMIT     = 4000;

  // One queued request. When wait_drained is set, the sender pauses before this
  // transaction until every earlier result has come back.
  typedef struct {
    in_item_t item;
    bit       wait_drained;
  } backlog_entry_t;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  sorted_hash_key_table_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the table. It is updated once for every request transaction, in
  // acceptance order, which is the order in which the unit serves requests.
  // ---------------------------------------------------------------------------
  key_t   table_keys [CAPACITY];
  value_t table_vals [CAPACITY];
  int     table_fill;

  // Results that have been computed for accepted requests but not yet seen.
  out_item_t awaited_results[$];

  // Returns the answer to one request and applies it to the shadow table.
  // The slot is the first position whose key is not below the requested key.
  function automatic out_item_t table_op_result(in_item_t req);
    out_item_t rsp;
    int        slot;
    bit        hit;
    rsp        = '0;
    rsp.status = STATUS_DONE;
    slot       = 0;
    while (slot < table_fill && table_keys[slot] < req.key_hash) begin
      slot++;
    end
    hit           = (slot < table_fill) && (table_keys[slot] == req.key_hash);
    rsp.key_found = hit;
    if (req.opcode == OP_LOOKUP) begin
      if (hit) begin
        rsp.entry_index = index_t'(slot);
        rsp.read_value  = data_t'(table_vals[slot]);
      end else begin
        rsp.entry_index = index_t'(table_fill);
      end
    end else if (hit) begin
      // Update of a present key: only the value changes.
      table_vals[slot] = value_t'(req.write_value);
      rsp.entry_index  = index_t'(slot);
    end else if (table_fill >= CAPACITY) begin
      // New key into a full table: nothing changes and the insert is refused.
      rsp.entry_index = index_t'(table_fill);
      rsp.status      = STATUS_FULL;
    end else begin
      // New key: move every later entry up one place, then write the new one.
      for (int i = table_fill; i > slot; i--) begin
        table_keys[i] = table_keys[i-1];
        table_vals[i] = table_vals[i-1];
      end
      table_keys[slot] = req.key_hash;
      table_vals[slot] = value_t'(req.write_value);
      table_fill++;
      rsp.entry_index  = index_t'(slot);
    end
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator tracks which keys it has put into the
  // table so that it can aim lookups and updates at present keys, and pick new
  // keys that are really absent. Since entries are never removed, the table
  // fills exactly once: the first random part is shaped to fill it with keys
  // that land at the front, at the back and next to existing keys, and the
  // second part runs against the full table.
  // ---------------------------------------------------------------------------
  backlog_entry_t op_backlog[$];
  key_t           stored_key_list[$];
  bit             key_stored[key_t];
  bit             hold_for_drain = 1'b0;
  int             total_items    = 0;

  function automatic void queue_op(opcode_t op, key_t key, data_t value);
    backlog_entry_t entry;
    entry.item.opcode      = op;
    entry.item.key_hash    = key;
    entry.item.write_value = value;
    entry.wait_drained     = hold_for_drain;
    hold_for_drain         = 1'b0;
    op_backlog.push_back(entry);
    if (op == OP_SET && !key_stored.exists(key) && stored_key_list.size() < CAPACITY) begin
      key_stored[key] = 1'b1;
      stored_key_list.push_back(key);
    end
  endfunction

  function automatic key_t stored_key_pick();
    return stored_key_list[$urandom_range(0, stored_key_list.size() - 1)];
  endfunction

  // Picks a key that is not in the table. Neighbors of stored keys exercise
  // the unsigned compare at its finest step, and low keys force long moves.
  function automatic key_t absent_key_pick();
    key_t key;
    do begin
      case ($urandom_range(0, 4))
        0: key = stored_key_pick() + 1'b1;
        1: key = stored_key_pick() - 1'b1;
        2: key = key_t'($urandom_range(0, 1023));
        3: key = 32'hFFFF_FC00 | key_t'($urandom_range(0, 1023));
        default: key = $urandom();
      endcase
    end while (key_stored.exists(key));
    return key;
  endfunction

  function automatic data_t value_pick();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic void build_stimulus();
    int roll;
    // Directed part: empty-table lookups at both key extremes, inserts at the
    // front, back and middle, hits at the first and last positions, updates of
    // present keys with extreme values, and misses between stored keys. The
    // write value of a lookup is set to show that it is ignored.
    queue_op(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(OP_SET,    32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(OP_SET,    32'h0000_0000, 32'h0000_0000);
    queue_op(OP_SET,    32'hFFFF_FFFF, 32'hA5A5_A5A5);
    queue_op(OP_SET,    32'h7FFF_FFFF, 32'h5A5A_5A5A);
    queue_op(OP_SET,    32'h8000_0001, 32'h0000_0001);
    queue_op(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    queue_op(OP_SET,    32'h8000_0000, 32'h1234_5678);
    queue_op(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    queue_op(OP_SET,    32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(OP_SET,    32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    queue_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(OP_LOOKUP, 32'h7FFF_FFFE, 32'h0000_0000);
    queue_op(OP_LOOKUP, 32'h8000_0002, 32'h0000_0000);
    queue_op(OP_SET,    32'h0000_0001, 32'hDEAD_BEEF);
    queue_op(OP_LOOKUP, 32'h8000_0001, 32'h0000_0000);

    // Filling part: mostly inserts of new keys, mixed with updates and lookups.
    hold_for_drain = 1'b1;
    while (stored_key_list.size() < CAPACITY) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        queue_op(OP_SET, absent_key_pick(), value_pick());
      end else if (roll < 60) begin
        queue_op(OP_SET, stored_key_pick(), value_pick());
      end else if (roll < 80) begin
        queue_op(OP_LOOKUP, stored_key_pick(), value_pick());
      end else begin
        queue_op(OP_LOOKUP, absent_key_pick(), value_pick());
      end
    end

    // Full-table part: refused inserts, updates, hits and misses. The sender
    // pauses at the start and every so often until the unit has drained.
    hold_for_drain = 1'b1;
    while (op_backlog.size() < ITEM_GOAL) begin
      if (op_backlog.size() % 120 == 0) begin
        hold_for_drain = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        queue_op(OP_SET, absent_key_pick(), value_pick());
      end else if (roll < 50) begin
        queue_op(OP_SET, stored_key_pick(), value_pick());
      end else if (roll < 75) begin
        queue_op(OP_LOOKUP, stored_key_pick(), value_pick());
      end else begin
        queue_op(OP_LOOKUP, absent_key_pick(), value_pick());
      end
    end
    total_items = op_backlog.size();
  endfunction

  // ---------------------------------------------------------------------------
  // Transaction counters. All but fail_count are written by one process with
  // a nonblocking assignment, so others read the value from before the edge.
  // ---------------------------------------------------------------------------
  int  requests_taken  = 0;
  int  results_taken   = 0;
  int  fail_count      = 0;
  int  stuck_cycles    = 0;
  wire no_idling;

  // Idling stops in the last part of the run and pauses every so often, so
  // that there are stretches where both sides run at full speed.
  assign no_idling = (requests_taken >= total_items - TAIL_ITEMS) ||
                     ((requests_taken / 50) % 4 == 3);

  // ---------------------------------------------------------------------------
  // Request driver. A request stays on the bus, unchanged, until the unit
  // accepts it. Between requests the driver may insert an idle burst, and it
  // holds back a request marked for draining until every result that was
  // predicted so far has been taken by the monitor.
  // ---------------------------------------------------------------------------
  bit             request_done;
  int             send_gap;
  backlog_entry_t next_entry;

  always @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      in_data        <= '0;
      requests_taken <= 0;
      table_fill     = 0;
      send_gap       = 0;
    end else begin
      request_done = in_valid && !in_stall;
      if (request_done) begin
        awaited_results.push_back(table_op_result(in_data));
        requests_taken <= requests_taken + 1;
      end
      if (in_valid && !request_done) begin
        // Still waiting for the unit: keep the request as it is.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (op_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else if (op_backlog[0].wait_drained &&
                   (request_done || requests_taken != results_taken)) begin
        // The counter of this edge's request is not updated yet, so a request
        // taken now makes the driver look again on the next cycle.
        in_valid <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        next_entry = op_backlog.pop_front();
        in_data  <= next_entry.item;
        in_valid <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. It stalls in random bursts, and once, part way into the
  // run, it holds off for a long stretch while the driver goes on offering
  // requests, so that the unit fills up and stalls its input.
  // ---------------------------------------------------------------------------
  int stall_left     = 0;
  int hold_off_left  = 0;
  bit hold_off_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_off_taken && requests_taken >= HOLD_OFF_AT) begin
      hold_off_taken = 1'b1;
      hold_off_left  = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!no_idling && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result transaction is checked field by field against the
  // oldest prediction. A result with nothing predicted is a failure as well.
  // ---------------------------------------------------------------------------
  out_item_t due;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_taken <= results_taken + 1;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: entry_index %0d", out_data.entry_index);
        fail_count++;
      end else begin
        due = awaited_results.pop_front();
        if (out_data.entry_index !== due.entry_index) begin
          $error("entry_index mismatch: expected %0d, actual %0d",
                 due.entry_index, out_data.entry_index);
          fail_count++;
        end
        if (out_data.key_found !== due.key_found) begin
          $error("key_found mismatch: expected %0b, actual %0b",
                 due.key_found, out_data.key_found);
          fail_count++;
        end
        if (out_data.read_value !== due.read_value) begin
          $error("read_value mismatch: expected %08h, actual %08h",
                 due.read_value, out_data.read_value);
          fail_count++;
        end
        if (out_data.status !== due.status) begin
          $error("status mismatch: expected %0b, actual %0b", due.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any accepted transaction on either side restarts the count.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Run control: reset once, wait for every request to be answered, let the
  // unit settle for longer than its slowest transaction, then report.
  // ---------------------------------------------------------------------------
  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (requests_taken != total_items || results_taken != total_items) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
